// ===== hw/rtl/fpd_pkg.sv =====
`default_nettype none

package fpd_pkg;

  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned KEY_W    = 4;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned TARGET_W = 40;
  localparam int unsigned VALUE_W  = 32;

  localparam logic [FUNC_W-1:0] FUNC_KEY   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_START = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_PULSE = 2'd2;

  localparam logic [KEY_W-1:0] KEY_DIGIT_MAX = 4'd9;
  localparam logic [KEY_W-1:0] KEY_POINT     = 4'd10;
  localparam logic [KEY_W-1:0] KEY_LITERS    = 4'd11;
  localparam logic [KEY_W-1:0] KEY_MONEY     = 4'd12;
  localparam logic [KEY_W-1:0] KEY_PRICE     = 4'd13;
  localparam logic [KEY_W-1:0] KEY_OK        = 4'd14;
  localparam logic [KEY_W-1:0] KEY_ESC       = 4'd15;

  localparam logic [MODE_W-1:0] MODE_NONE   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PRICE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MONEY  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_LITERS = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  key_code;
  } fpd_in_t;

  typedef struct packed {
    logic                valve_open;
    logic [MODE_W-1:0]   entry_mode;
    logic [TARGET_W-1:0] target_q8;
    logic [VALUE_W-1:0]  pulse_count;
    logic [VALUE_W-1:0]  amount_due;
    logic [VALUE_W-1:0]  quote;
    logic                done_res;
    logic                error;
  } fpd_out_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fpd_in_if.sv =====
`default_nettype none

interface fpd_in_if;
  import fpd_pkg::*;

  logic    valid;
  logic    ready;
  fpd_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/fpd_out_if.sv =====
`default_nettype none

interface fpd_out_if;
  import fpd_pkg::*;

  logic     valid;
  logic     ready;
  fpd_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/fuel_preset_dispense_controller_core.sv =====
// Preset fuel-dispense controller.
// in_i carries one event per beat: a key press, the pump start button or a
// flow pulse. out_o returns exactly one status beat per event: valve, entry
// mode, target, pulse count, amount due, quote, completion and error flag.
// One event is in work at a time; in_i.ready is high only while the
// sequencer is idle. A shared adder/subtractor does the serial divide and
// multiply steps. After accept, plain keys, start and pulses without
// completion pass from the execute step straight to the final step; a
// completing pulse first runs a serial count*price multiply; OK with liters,
// or with zero price, runs a serial quote multiply; OK with money runs a
// serial restoring divide, then the serial quote. Once the output register
// is free, in_i.ready returns in the same cycle that the new beat is loaded
// into it. A finished result sits in the output register while the next
// event is accepted; a stalled receiver holds the sequencer in its final
// step until the output register frees up.
// Reset clears all entry values, target, count, valve, latched amounts and
// the error flag; no output beat is pending after reset.
`default_nettype none

module fuel_preset_dispense_controller_core #(
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned FRAC_BITS  = 8
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  fpd_in_if.sink       in_i,
  fpd_out_if.source    out_o
);
  import fpd_pkg::*;

  localparam int unsigned VB = VALUE_BITS;
  localparam int unsigned FB = FRAC_BITS;
  localparam int unsigned TW = VALUE_BITS + FRAC_BITS;
  localparam int unsigned CW = $clog2(TW + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_QMUL = 3'd3;
  localparam logic [2:0] S_AMUL = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [FUNC_W-1:0] func_q, func_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [MODE_W-1:0] mode_q, mode_d;
  logic [VB-1:0]     price_q, price_d;
  logic [VB-1:0]     money_q, money_d;
  logic [VB-1:0]     liters_q, liters_d;
  logic [TW-1:0]     target_q, target_d;
  logic [VB-1:0]     counted_q, counted_d;
  logic              valve_q, valve_d;
  logic [VB-1:0]     amount_q, amount_d;
  logic [VB-1:0]     quote_q, quote_d;
  logic              err_q, err_d;
  logic              done_q, done_d;
  logic [TW-1:0]     work_q, work_d;
  logic [TW-1:0]     shf_q, shf_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  fpd_out_t          out_data_q, out_data_d;

  logic [TW-1:0] add_a, add_b, add_bx;
  logic          add_sub;
  logic [TW:0]   add_sum;
  logic [VB:0]   div_sh;
  logic [VB-1:0] cnt_inc;
  logic [TW-1:0] quo_next;
  logic          out_load;

  // shared adder/subtractor
  assign div_sh = {work_q[VB-1:0], shf_q[TW-1]};

  always_comb begin
    add_a   = {work_q[TW-2:0], 1'b0};
    add_b   = '0;
    add_sub = 1'b0;
    case (state_q)
      S_DIV: begin
        add_a   = TW'(div_sh);
        add_b   = TW'(price_q);
        add_sub = 1'b1;
      end
      S_QMUL: add_b = shf_q[TW-1] ? target_q : '0;
      S_AMUL: add_b = shf_q[TW-1] ? TW'(counted_q) : '0;
      default: add_b = '0;
    endcase
  end

  assign add_bx  = add_sub ? ~add_b : add_b;
  assign add_sum = {1'b0, add_a} + {1'b0, add_bx} + (TW + 1)'(add_sub);

  assign quo_next = {shf_q[TW-2:0], add_sum[TW]};
  assign cnt_inc  = counted_q + VB'(1);
  assign out_load = (state_q == S_FIN) && (!out_valid_q || out_o.ready);

  assign in_i.ready  = (state_q == S_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  always_comb begin
    state_d   = state_q;
    func_d    = func_q;
    key_d     = key_q;
    mode_d    = mode_q;
    price_d   = price_q;
    money_d   = money_q;
    liters_d  = liters_q;
    target_d  = target_q;
    counted_d = counted_q;
    valve_d   = valve_q;
    amount_d  = amount_q;
    quote_d   = quote_q;
    err_d     = err_q;
    done_d    = done_q;
    work_d    = work_q;
    shf_d     = shf_q;
    cnt_d     = cnt_q;

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          func_d  = in_i.data.func;
          key_d   = in_i.data.key_code;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        done_d  = 1'b0;
        state_d = S_FIN;
        case (func_q)
          FUNC_KEY: begin
            if (key_q <= KEY_DIGIT_MAX) begin
              case (mode_q)
                MODE_PRICE:  price_d  = (price_q << 3) + (price_q << 1) + VB'(key_q);
                MODE_MONEY:  money_d  = (money_q << 3) + (money_q << 1) + VB'(key_q);
                MODE_LITERS: liters_d = (liters_q << 3) + (liters_q << 1) + VB'(key_q);
                default:     mode_d   = mode_q;
              endcase
            end else if (key_q == KEY_LITERS) begin
              mode_d  = MODE_LITERS;
              money_d = '0;
            end else if (key_q == KEY_MONEY) begin
              mode_d   = MODE_MONEY;
              liters_d = '0;
            end else if (key_q == KEY_PRICE) begin
              mode_d = MODE_PRICE;
            end else if (key_q == KEY_OK) begin
              if (mode_q == MODE_PRICE) begin
                mode_d = MODE_NONE;
              end else if (mode_q == MODE_MONEY || mode_q == MODE_LITERS) begin
                counted_d = '0;
                mode_d    = MODE_NONE;
                work_d    = '0;
                if (liters_q != '0) begin
                  target_d = {liters_q, {FB{1'b0}}};
                  err_d    = 1'b0;
                  shf_d    = {price_q, {FB{1'b0}}};
                  cnt_d    = CW'(VB);
                  state_d  = S_QMUL;
                end else if (price_q == '0) begin
                  target_d = '0;
                  err_d    = 1'b1;
                  shf_d    = {price_q, {FB{1'b0}}};
                  cnt_d    = CW'(VB);
                  state_d  = S_QMUL;
                end else begin
                  err_d   = 1'b0;
                  shf_d   = {money_q, {FB{1'b0}}};
                  cnt_d   = CW'(TW);
                  state_d = S_DIV;
                end
              end
            end else if (key_q == KEY_ESC) begin
              price_d  = '0;
              money_d  = '0;
              liters_d = '0;
              mode_d   = MODE_NONE;
              err_d    = 1'b0;
            end
          end
          FUNC_START: begin
            if (target_q != '0) valve_d = 1'b1;
          end
          FUNC_PULSE: begin
            if (target_q != '0) begin
              counted_d = cnt_inc;
              if ({cnt_inc, {FB{1'b0}}} >= target_q) begin
                valve_d  = 1'b0;
                target_d = '0;
                liters_d = '0;
                money_d  = '0;
                done_d   = 1'b1;
                work_d   = '0;
                shf_d    = {price_q, {FB{1'b0}}};
                cnt_d    = CW'(VB);
                state_d  = S_AMUL;
              end
            end
          end
          default: state_d = S_FIN;
        endcase
      end
      S_DIV: begin
        work_d = add_sum[TW] ? TW'(add_sum[VB-1:0]) : TW'(div_sh[VB-1:0]);
        shf_d  = quo_next;
        cnt_d  = cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          target_d = quo_next;
          work_d   = '0;
          shf_d    = {price_q, {FB{1'b0}}};
          cnt_d    = CW'(VB);
          state_d  = S_QMUL;
        end
      end
      S_QMUL: begin
        work_d = add_sum[TW-1:0];
        shf_d  = {shf_q[TW-2:0], 1'b0};
        cnt_d  = cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          quote_d = add_sum[TW-1:FB];
          state_d = S_FIN;
        end
      end
      S_AMUL: begin
        work_d = add_sum[TW-1:0];
        shf_d  = {shf_q[TW-2:0], 1'b0};
        cnt_d  = cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          amount_d = add_sum[VB-1:0];
          state_d  = S_FIN;
        end
      end
      S_FIN: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_load) begin
      out_valid_d            = 1'b1;
      out_data_d.valve_open  = valve_q;
      out_data_d.entry_mode  = mode_q;
      out_data_d.target_q8   = TARGET_W'(target_q);
      out_data_d.pulse_count = VALUE_W'(counted_q);
      out_data_d.amount_due  = VALUE_W'(amount_q);
      out_data_d.quote       = VALUE_W'(quote_q);
      out_data_d.done_res    = done_q;
      out_data_d.error       = err_q;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= MODE_NONE;
      price_q     <= '0;
      money_q     <= '0;
      liters_q    <= '0;
      target_q    <= '0;
      counted_q   <= '0;
      valve_q     <= 1'b0;
      amount_q    <= '0;
      quote_q     <= '0;
      err_q       <= 1'b0;
      done_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      price_q     <= price_d;
      money_q     <= money_d;
      liters_q    <= liters_d;
      target_q    <= target_d;
      counted_q   <= counted_d;
      valve_q     <= valve_d;
      amount_q    <= amount_d;
      quote_q     <= quote_d;
      err_q       <= err_d;
      done_q      <= done_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q     <= func_d;
    key_q      <= key_d;
    work_q     <= work_d;
    shf_q      <= shf_d;
    out_data_q <= out_data_d;
  end

`ifndef NO_ASSERTIONS
  a_valve_needs_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(valve_q) |-> target_q != '0)
    else $error("valve opened without a target");

  a_div_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> work_q[VB-1:0] < price_q)
    else $error("divide remainder not below price");

  a_fin_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q && state_q == S_IDLE)
    else $error("final step did not present a beat");

  a_done_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q.done_res |-> !out_data_q.valve_open &&
      out_data_q.target_q8 == '0)
    else $error("completion beat with valve open or target left");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/fpd_status_checker.sv =====
`timescale 1ns / 1ps

module fpd_status_checker (
  input  wire         clk_i,
  input  wire         rst_ni,
  fpd_in_if           ev_i,
  fpd_out_if          st_i,
  output int unsigned err_cnt_o,
  output int unsigned pending_o
);
  import fpd_pkg::*;

  localparam int unsigned FRAC     = 8;
  localparam int unsigned DEC_BASE = 10;

  logic [MODE_W-1:0]   mode_q;
  logic [VALUE_W-1:0]  price_q;
  logic [VALUE_W-1:0]  money_q;
  logic [VALUE_W-1:0]  liters_q;
  logic [TARGET_W-1:0] target_q;
  logic [VALUE_W-1:0]  counted_q;
  logic                valve_q;
  logic [VALUE_W-1:0]  amount_q;
  logic [VALUE_W-1:0]  quote_q;
  logic                err_q;

  fpd_out_t    status_q[$];
  int unsigned n_err = 0;
  int unsigned n_pend = 0;

  assign err_cnt_o = n_err;
  assign pending_o = n_pend;

  task automatic report(input string msg);
    $display("%0t ns: %s", $time, msg);
    n_err++;
  endtask

  task automatic confirm_order();
    logic [TARGET_W+VALUE_W-1:0] prod;
    if (liters_q != '0) begin
      target_q = TARGET_W'(liters_q) << FRAC;
      err_q    = 1'b0;
    end else if (price_q == '0) begin
      target_q = '0;
      err_q    = 1'b1;
    end else begin
      target_q = (TARGET_W'(money_q) << FRAC) / TARGET_W'(price_q);
      err_q    = 1'b0;
    end
    counted_q = '0;
    prod      = (TARGET_W+VALUE_W)'(target_q) * (TARGET_W+VALUE_W)'(price_q);
    quote_q   = VALUE_W'(prod >> FRAC);
    mode_q    = MODE_NONE;
  endtask

  task automatic press_key(input logic [KEY_W-1:0] k);
    if (k <= KEY_DIGIT_MAX) begin
      case (mode_q)
        MODE_PRICE:  price_q  = price_q * DEC_BASE + VALUE_W'(k);
        MODE_MONEY:  money_q  = money_q * DEC_BASE + VALUE_W'(k);
        MODE_LITERS: liters_q = liters_q * DEC_BASE + VALUE_W'(k);
        default: ;
      endcase
    end else begin
      case (k)
        KEY_LITERS: begin
          mode_q  = MODE_LITERS;
          money_q = '0;
        end
        KEY_MONEY: begin
          mode_q   = MODE_MONEY;
          liters_q = '0;
        end
        KEY_PRICE: mode_q = MODE_PRICE;
        KEY_OK: begin
          if (mode_q == MODE_PRICE) begin
            mode_q = MODE_NONE;
          end else if (mode_q == MODE_MONEY || mode_q == MODE_LITERS) begin
            confirm_order();
          end
        end
        KEY_ESC: begin
          price_q  = '0;
          money_q  = '0;
          liters_q = '0;
          mode_q   = MODE_NONE;
          err_q    = 1'b0;
        end
        default: ;
      endcase
    end
  endtask

  task automatic advance_dispenser(input fpd_in_t ev, output fpd_out_t st);
    logic done;
    done = 1'b0;
    case (ev.func)
      FUNC_KEY: press_key(ev.key_code);
      FUNC_START: begin
        if (target_q != '0) valve_q = 1'b1;
      end
      FUNC_PULSE: begin
        if (target_q != '0) begin
          counted_q = counted_q + 1'b1;
          if ((TARGET_W'(counted_q) << FRAC) >= target_q) begin
            valve_q   = 1'b0;
            amount_q  = counted_q * price_q;
            target_q  = '0;
            liters_q  = '0;
            money_q   = '0;
            done      = 1'b1;
          end
        end
      end
      default: ;
    endcase
    st.valve_open  = valve_q;
    st.entry_mode  = mode_q;
    st.target_q8   = target_q;
    st.pulse_count = counted_q;
    st.amount_due  = amount_q;
    st.quote       = quote_q;
    st.done_res    = done;
    st.error       = err_q;
  endtask

  task automatic check_status(input fpd_out_t got);
    fpd_out_t want;
    if (status_q.size() == 0) begin
      report("status beat with nothing expected");
      return;
    end
    want = status_q.pop_front();
    if (got.valve_open !== want.valve_open)
      report($sformatf("valve_open got %0h expected %0h", got.valve_open, want.valve_open));
    if (got.entry_mode !== want.entry_mode)
      report($sformatf("entry_mode got %0h expected %0h", got.entry_mode, want.entry_mode));
    if (got.target_q8 !== want.target_q8)
      report($sformatf("target_q8 got %0h expected %0h", got.target_q8, want.target_q8));
    if (got.pulse_count !== want.pulse_count)
      report($sformatf("pulse_count got %0h expected %0h", got.pulse_count,
                       want.pulse_count));
    if (got.amount_due !== want.amount_due)
      report($sformatf("amount_due got %0h expected %0h", got.amount_due, want.amount_due));
    if (got.quote !== want.quote)
      report($sformatf("quote got %0h expected %0h", got.quote, want.quote));
    if (got.done_res !== want.done_res)
      report($sformatf("done_res got %0h expected %0h", got.done_res, want.done_res));
    if (got.error !== want.error)
      report($sformatf("error got %0h expected %0h", got.error, want.error));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    fpd_out_t st;
    if (!rst_ni) begin
      mode_q    = MODE_NONE;
      price_q   = '0;
      money_q   = '0;
      liters_q  = '0;
      target_q  = '0;
      counted_q = '0;
      valve_q   = 1'b0;
      amount_q  = '0;
      quote_q   = '0;
      err_q     = 1'b0;
      status_q.delete();
      n_pend <= 0;
    end else begin
      if (st_i.valid && st_i.ready) check_status(st_i.data);
      if (ev_i.valid && ev_i.ready) begin
        advance_dispenser(ev_i.data, st);
        status_q.push_back(st);
      end
      n_pend <= status_q.size();
    end
  end

endmodule

// ===== tb/sv/tb_fuel_preset_dispense_controller_core.sv =====
`timescale 1ns / 1ps

module tb_fuel_preset_dispense_controller_core;
  import fpd_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;
  localparam int unsigned N_ITEMS = 1900;

  logic        clk_i;
  logic        rst_ni;
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int unsigned n_sent;
  int unsigned n_err;
  int unsigned n_pend;

  fpd_in_if  ev_if ();
  fpd_out_if st_if ();

  fuel_preset_dispense_controller_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (ev_if),
    .out_o  (st_if)
  );

  fpd_status_checker u_chk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ev_i      (ev_if),
    .st_i      (st_if),
    .err_cnt_o (n_err),
    .pending_o (n_pend)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    st_if.ready <= rst_ni && ($urandom_range(99) >= snk_idle_pct);
  end

  task automatic send_beat(input logic [FUNC_W-1:0] f, input logic [KEY_W-1:0] k);
    if ($urandom_range(99) < src_idle_pct) begin
      ev_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    ev_if.valid         <= 1'b1;
    ev_if.data.func     <= f;
    ev_if.data.key_code <= k;
    do @(posedge clk_i); while (!ev_if.ready);
    n_sent++;
  endtask

  task automatic type_value(input int unsigned n_digits);
    repeat (n_digits) send_beat(FUNC_KEY, KEY_W'($urandom_range(9)));
  endtask

  // hold off the sender until every status beat is back
  task automatic drain();
    ev_if.valid <= 1'b0;
    @(posedge clk_i);
    while (n_pend != 0) @(posedge clk_i);
  endtask

  task automatic run_order();
    int unsigned n_pulses;
    if ($urandom_range(19) == 0) send_beat(FUNC_KEY, KEY_ESC);
    if ($urandom_range(9) == 0) begin
      send_beat(FUNC_KEY, KEY_MONEY);
      type_value($urandom_range(1, 3));
      send_beat(FUNC_KEY, KEY_LITERS);
      type_value($urandom_range(1));
    end else if ($urandom_range(1) == 0) begin
      send_beat(FUNC_KEY, KEY_LITERS);
      type_value(($urandom_range(15) == 0) ? $urandom_range(10, 12) : $urandom_range(1));
    end else begin
      send_beat(FUNC_KEY, KEY_MONEY);
      type_value(($urandom_range(15) == 0) ? $urandom_range(10, 12) : $urandom_range(1, 4));
    end
    if ($urandom_range(9) == 0) send_beat(FUNC_KEY, KEY_POINT);
    send_beat(FUNC_KEY, KEY_OK);
    if ($urandom_range(7) != 0) send_beat(FUNC_START, KEY_W'($urandom_range(15)));
    n_pulses = $urandom_range(1, 24);
    repeat (n_pulses) begin
      if ($urandom_range(15) == 0) send_beat(FUNC_W'($urandom_range(3)),
                                             KEY_W'($urandom_range(15)));
      send_beat(FUNC_PULSE, KEY_W'($urandom_range(15)));
    end
  endtask

  task automatic run_random_sequence();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 10) begin
      send_beat(FUNC_W'($urandom_range(3)), KEY_W'($urandom_range(15)));
    end else if (pick < 28) begin
      send_beat(FUNC_KEY, KEY_PRICE);
      if ($urandom_range(9) == 0) send_beat(FUNC_KEY, KEY_ESC);
      type_value(($urandom_range(9) == 0) ? $urandom_range(10, 12) : $urandom_range(3));
      send_beat(FUNC_KEY, ($urandom_range(9) == 0) ? KEY_ESC : KEY_OK);
    end else begin
      run_order();
    end
  endtask

  task automatic run_directed();
    send_beat(FUNC_NONE, KEY_ESC);
    send_beat(FUNC_KEY, 4'd5);
    send_beat(FUNC_KEY, KEY_POINT);
    send_beat(FUNC_KEY, KEY_OK);
    send_beat(FUNC_START, KEY_OK);
    send_beat(FUNC_PULSE, KEY_ESC);
    // money order with no price: error flag, zero target
    send_beat(FUNC_KEY, KEY_MONEY);
    send_beat(FUNC_KEY, KEY_OK);
    send_beat(FUNC_KEY, KEY_ESC);
    send_beat(FUNC_KEY, KEY_PRICE);
    send_beat(FUNC_KEY, 4'd5);
    send_beat(FUNC_KEY, KEY_POINT);
    send_beat(FUNC_KEY, 4'd0);
    send_beat(FUNC_KEY, KEY_OK);
    send_beat(FUNC_KEY, KEY_MONEY);
    send_beat(FUNC_KEY, 4'd9);
    send_beat(FUNC_KEY, 4'd9);
    send_beat(FUNC_KEY, KEY_OK);
    send_beat(FUNC_START, 4'd0);
    repeat (2) send_beat(FUNC_PULSE, 4'd0);
    // pulses count with the valve closed
    send_beat(FUNC_KEY, KEY_LITERS);
    send_beat(FUNC_KEY, 4'd2);
    send_beat(FUNC_KEY, KEY_OK);
    repeat (2) send_beat(FUNC_PULSE, 4'd0);
  endtask

  initial begin
    ev_if.valid  = 1'b0;
    ev_if.data   = '0;
    st_if.ready  = 1'b0;
    rst_ni       = 1'b0;
    src_idle_pct = 27;
    snk_idle_pct = 79;
    n_sent       = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          src_idle_pct = 27;
          snk_idle_pct = 79;
        end
        1: begin
          src_idle_pct = 79;
          snk_idle_pct = 27;
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
      endcase
      while (n_sent < N_ITEMS * (ph + 1) / 3) run_random_sequence();
      drain();
    end
    repeat (100) @(posedge clk_i);
    if (n_err == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
